[src/dlfc_pkg.sv]
`default_nettype none

package dlfc_pkg;

    // Command codes
    localparam logic [2:0] OP_SET_BASE   = 3'd0;
    localparam logic [2:0] OP_SET_OFFSET = 3'd1;
    localparam logic [2:0] OP_ORIGIN     = 3'd2;
    localparam logic [2:0] OP_JUMP       = 3'd3;
    localparam logic [2:0] OP_CALL       = 3'd4;
    localparam logic [2:0] OP_RETURN     = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Address masks and the return step
    localparam logic [31:0] JUMP_MASK   = 32'h0FFF_FFFC;
    localparam logic [31:0] CALL_MASK   = 32'h0FFF_FFFF;
    localparam logic [31:0] BASE_MASK   = 32'hFF00_0000;
    localparam logic [31:0] RETURN_STEP = 32'd4;

    localparam int DEF_STACK_DEPTH = 8;

endpackage

`default_nettype wire

[src/display_list_flow_control.sv]
`default_nettype none

// Display list flow control with a call/return stack.
//
// Command channel: a beat (op, param, current address) is taken at a rising
// edge where start is high and busy is low. Busy is raised in the cycle
// after that edge while the command resolves, and is low when o_valid is.
// Result channel: o_valid is high for exactly one cycle, registered from the
// pending flag set at the accepting edge, with the next fetch address and a
// status code. The receiver cannot stall; o_valid drops after that cycle.
// A command is taken only while none is pending, as the return-address RAM
// has a registered read: the top entry is read in the accept cycle and the
// command is resolved (pop, push, base/offset update) in the next one.
// A new command may be presented in the same cycle the previous result is
// shown.
// Reset (i_rst_n low at a clock edge) clears base, offset, stack depth and
// the pending command. RAM entries are not cleared; an entry is used only
// after a call has written it.

module display_list_flow_control
    import dlfc_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  i_op,
    input  wire logic [23:0] i_param,
    input  wire logic [31:0] i_current_address,
    output logic             o_valid,
    output logic [31:0]      o_next_address,
    output logic [1:0]       o_status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

    logic          r_pend;
    logic [2:0]    r_op;
    logic [23:0]   r_param;
    logic [31:0]   r_cur;
    logic [31:0]   r_base,   n_base;
    logic [31:0]   r_offset, n_offset;
    logic [DW-1:0] r_depth,  n_depth;
    logic [31:0]   n_next;
    logic [1:0]    n_status;
    logic          w_accept;
    logic          w_push;
    logic [DW-1:0] w_top;
    logic [31:0]   w_rdata;
    logic [31:0]   w_sel;

    assign w_accept = start && !busy;
    assign busy     = r_pend;
    assign w_top    = r_depth - DW'(1);
    assign w_sel    = r_base | {8'd0, r_param};

    // Return-address stack; top read at accept, push on resolve
    dlfc_ram #(
        .WIDTH(32),
        .DEPTH(STACK_DEPTH),
        .AW   (AW)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_push),
        .i_waddr(r_depth[AW-1:0]),
        .i_wdata(r_cur + RETURN_STEP),
        .i_raddr(w_top[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // Resolve the pending command
    always_comb begin
        n_base   = r_base;
        n_offset = r_offset;
        n_depth  = r_depth;
        n_next   = r_cur;
        n_status = ST_OK;
        w_push   = 1'b0;
        if (r_pend) begin
            case (r_op)
                OP_SET_BASE: begin
                    n_base = {r_param, 8'd0} & BASE_MASK;
                end
                OP_SET_OFFSET: begin
                    n_offset = {r_param, 8'd0};
                end
                OP_ORIGIN: begin
                    n_offset = r_cur;
                end
                OP_JUMP: begin
                    n_next = (w_sel & JUMP_MASK) + r_offset;
                end
                OP_CALL: begin
                    if (r_depth >= DEPTH_FULL) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        w_push  = 1'b1;
                        n_depth = r_depth + DW'(1);
                        n_next  = (w_sel & CALL_MASK) + r_offset;
                    end
                end
                OP_RETURN: begin
                    if (r_depth == '0) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_depth = w_top;
                        n_next  = w_rdata;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            o_valid  <= 1'b0;
            r_base   <= '0;
            r_offset <= '0;
            r_depth  <= '0;
        end else begin
            r_pend   <= w_accept;
            o_valid  <= r_pend;
            r_base   <= n_base;
            r_offset <= n_offset;
            r_depth  <= n_depth;
        end
    end

    // Capture the command beat and the result
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_param <= i_param;
            r_cur   <= i_current_address;
        end
        if (r_pend) begin
            o_next_address <= n_next;
            o_status       <= n_status;
        end
    end

    a_depth_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_FULL)
        else $error("stack depth beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("busy not raised after accept");

    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_valid)
        else $error("no result after pending command");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while a command is pending");

    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_OVERFLOW) |-> r_depth == DEPTH_FULL)
        else $error("overflow reported with room on the stack");

    a_under_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_UNDERFLOW) |-> r_depth == '0)
        else $error("underflow reported with entries on the stack");

endmodule

`default_nettype wire

[src/dlfc_ram.sv]
`default_nettype none

module dlfc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
